// ===== design/assert_macros.svh =====
// Assertion macros shared by the filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mbc_pkg.sv =====
// Shared types, constants and coefficient table of the biquad cascade filter.
`default_nettype none

package mbc_pkg;

   // Parameter defaults.
   localparam int unsigned CHANNELS_DEF            = 9;
   localparam int unsigned SAMPLE_BITS_DEF         = 16;
   localparam int unsigned STATE_FRACTION_BITS_DEF = 16;

   // Fixed structure of the cascade.
   localparam int unsigned SECTIONS         = 3;
   localparam int unsigned SEC_BITS         = 2;
   localparam int unsigned CHAN_BITS        = 4;
   localparam int unsigned PORT_SAMPLE_BITS = 16;

   // Arithmetic formats.
   localparam int unsigned STATE_BITS = 40;
   localparam int unsigned COEF_BITS  = 24;
   localparam int unsigned COEF_FRAC  = 20;
   localparam int unsigned HALF_BITS  = 20;
   localparam int unsigned PART_BITS  = HALF_BITS + 1;
   localparam int unsigned PROD_BITS  = COEF_BITS + PART_BITS;
   localparam int unsigned ACC_BITS   = 66;

   // Coefficient selector. The feedback terms are stored negated so that
   // every section sum is a plain sum of products.
   typedef enum logic [2:0] {
      COEF_A1N,
      COEF_A2N,
      COEF_B0,
      COEF_B1,
      COEF_B2
   } coef_sel_type;

   // Multiplier operand selector.
   typedef enum logic [1:0] {
      OPD_D1,
      OPD_D2,
      OPD_W
   } opd_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load_in;
      logic                rd_en;
      logic                acc_init_x;
      logic                acc_init_zero;
      logic                mul_en;
      coef_sel_type        coef_sel;
      opd_sel_type         opd_sel;
      logic                hi_half;
      logic                w_take;
      logic                y_take;
      logic                out_take;
      logic [SEC_BITS-1:0] sec;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ch_ok;
   } dp_status_type;

   // Q3.20 coefficients of the three second-order sections.
   function automatic logic signed [COEF_BITS-1:0] coef_value(
      input logic [SEC_BITS-1:0] sec,
      input coef_sel_type        sel
   );
      logic signed [COEF_BITS-1:0] c;
      c = '0;
      case (sel)
         COEF_B0: begin
            case (sec)
               2'd0:    c = 24'sd1363;
               2'd1:    c = 24'sd1048576;
               2'd2:    c = 24'sd1048576;
               default: c = '0;
            endcase
         end
         COEF_B1: begin
            case (sec)
               2'd0:    c = 24'sd1363;
               2'd1:    c = 24'sd2098830;
               2'd2:    c = 24'sd2096523;
               default: c = '0;
            endcase
         end
         COEF_B2: begin
            case (sec)
               2'd0:    c = 24'sd0;
               2'd1:    c = 24'sd1050254;
               2'd2:    c = 24'sd1047947;
               default: c = '0;
            endcase
         end
         COEF_A1N: begin
            case (sec)
               2'd0:    c = 24'sd534249;
               2'd1:    c = 24'sd1149868;
               2'd2:    c = 24'sd1435815;
               default: c = '0;
            endcase
         end
         COEF_A2N: begin
            case (sec)
               2'd0:    c = 24'sd0;
               2'd1:    c = -24'sd372664;
               2'd2:    c = -24'sd726244;
               default: c = '0;
            endcase
         end
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/mbc_ctrl.sv =====
// Sequencing controller of the biquad cascade filter.
`default_nettype none
`include "assert_macros.svh"

module mbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  mbc_pkg::dp_status_type status,
   output mbc_pkg::dp_cmd_type    cmd
);
   import mbc_pkg::*;

   localparam int unsigned STEP_BITS = 4;

   // Steps of one section. Each product takes a low and a high partial step.
   localparam logic [STEP_BITS-1:0] STEP_READ    = 4'd0;
   localparam logic [STEP_BITS-1:0] STEP_A1_LO   = 4'd1;
   localparam logic [STEP_BITS-1:0] STEP_A1_HI   = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_A2_LO   = 4'd3;
   localparam logic [STEP_BITS-1:0] STEP_A2_HI   = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_W_FLUSH = 4'd5;
   localparam logic [STEP_BITS-1:0] STEP_W_TAKE  = 4'd6;
   localparam logic [STEP_BITS-1:0] STEP_B0_LO   = 4'd7;
   localparam logic [STEP_BITS-1:0] STEP_B0_HI   = 4'd8;
   localparam logic [STEP_BITS-1:0] STEP_B1_LO   = 4'd9;
   localparam logic [STEP_BITS-1:0] STEP_B1_HI   = 4'd10;
   localparam logic [STEP_BITS-1:0] STEP_B2_LO   = 4'd11;
   localparam logic [STEP_BITS-1:0] STEP_B2_HI   = 4'd12;
   localparam logic [STEP_BITS-1:0] STEP_Y_FLUSH = 4'd13;
   localparam logic [STEP_BITS-1:0] STEP_Y_TAKE  = 4'd14;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SECT,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [SEC_BITS-1:0]  sec_ff, sec_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      sec_in       = sec_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      cmd               = '0;
      cmd.coef_sel      = COEF_B0;
      cmd.opd_sel       = OPD_D1;
      cmd.sec           = sec_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_SECT;
               sec_in      = '0;
               step_in     = STEP_READ;
            end
         end
         ST_SECT: begin
            step_in = step_ff + STEP_BITS'(1);
            case (step_ff)
               STEP_READ: begin
                  cmd.rd_en      = 1'b1;
                  cmd.acc_init_x = 1'b1;
                  // A channel outside the table skips the whole cascade.
                  if (sec_ff == '0 && !status.ch_ok) begin
                     state_in = ST_DONE;
                  end
               end
               STEP_A1_LO: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_A1N; cmd.opd_sel = OPD_D1;
               end
               STEP_A1_HI: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_A1N; cmd.opd_sel = OPD_D1;
                  cmd.hi_half = 1'b1;
               end
               STEP_A2_LO: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_A2N; cmd.opd_sel = OPD_D2;
               end
               STEP_A2_HI: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_A2N; cmd.opd_sel = OPD_D2;
                  cmd.hi_half = 1'b1;
               end
               STEP_W_TAKE: begin
                  cmd.w_take        = 1'b1;
                  cmd.acc_init_zero = 1'b1;
               end
               STEP_B0_LO: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_B0; cmd.opd_sel = OPD_W;
               end
               STEP_B0_HI: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_B0; cmd.opd_sel = OPD_W;
                  cmd.hi_half = 1'b1;
               end
               STEP_B1_LO: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_B1; cmd.opd_sel = OPD_D1;
               end
               STEP_B1_HI: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_B1; cmd.opd_sel = OPD_D1;
                  cmd.hi_half = 1'b1;
               end
               STEP_B2_LO: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_B2; cmd.opd_sel = OPD_D2;
               end
               STEP_B2_HI: begin
                  cmd.mul_en = 1'b1; cmd.coef_sel = COEF_B2; cmd.opd_sel = OPD_D2;
                  cmd.hi_half = 1'b1;
               end
               STEP_Y_TAKE: begin
                  cmd.y_take = 1'b1;
                  step_in    = STEP_READ;
                  if (sec_ff == SEC_BITS'(SECTIONS - 1)) begin
                     state_in = ST_DONE;
                  end else begin
                     sec_in = sec_ff + SEC_BITS'(1);
                  end
               end
               // Flush steps let the last partial product reach the sum.
               STEP_W_FLUSH, STEP_Y_FLUSH: begin
               end
               default: begin
               end
            endcase
         end
         ST_DONE: begin
            // Load the output register once it is empty or being drained.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_take = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sec_ff       <= '0;
         step_ff      <= STEP_READ;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_load_starts_cascade, clock, reset, cmd.load_in, state_ff == ST_SECT && sec_ff == '0 && step_ff == STEP_READ, "accepted beat did not start the first section")
   `ASSERT_IMPLIES(a_section_in_range, clock, reset, state_ff == ST_SECT, sec_ff < SEC_BITS'(SECTIONS), "section counter out of range")
   `ASSERT_NEXT(a_out_take_valid, clock, reset, cmd.out_take, rsp_valid_ff, "loaded result not presented")

endmodule

`default_nettype wire

// ===== design/mbc_datapath.sv =====
// Datapath of the biquad cascade filter: delay store, shared multiplier and accumulator.
`default_nettype none
`include "assert_macros.svh"

module mbc_datapath #(
   parameter int unsigned CHANNELS            = mbc_pkg::CHANNELS_DEF,
   parameter int unsigned SAMPLE_BITS         = mbc_pkg::SAMPLE_BITS_DEF,
   parameter int unsigned STATE_FRACTION_BITS = mbc_pkg::STATE_FRACTION_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  mbc_pkg::dp_cmd_type                           cmd,
   output mbc_pkg::dp_status_type                        status,
   input  logic        [mbc_pkg::CHAN_BITS-1:0]          req_channel,
   input  logic signed [mbc_pkg::PORT_SAMPLE_BITS-1:0]   req_sample,
   output logic        [mbc_pkg::CHAN_BITS-1:0]          rsp_channel_out,
   output logic signed [mbc_pkg::PORT_SAMPLE_BITS-1:0]   rsp_filtered
);
   import mbc_pkg::*;

   localparam int unsigned DEPTH    = CHANNELS * SECTIONS;
   localparam int unsigned IDX_BITS = $clog2(DEPTH);
   localparam int unsigned IDX_WIDE = CHAN_BITS + SEC_BITS + 2;
   localparam int unsigned ZEXT_BITS = 32;

   localparam logic signed [ACC_BITS-1:0] ONE_W       = ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] ROUND_HALF  = ONE_W <<< (COEF_FRAC - 1);
   localparam logic signed [ACC_BITS-1:0] OUT_HALF    = ONE_W <<< (STATE_FRACTION_BITS - 1);
   localparam logic signed [ACC_BITS-1:0] STATE_MAX_W = (ONE_W <<< (STATE_BITS - 1)) - ONE_W;
   localparam logic signed [ACC_BITS-1:0] STATE_MIN_W = -STATE_MAX_W - ONE_W;
   localparam logic signed [ACC_BITS-1:0] OUT_MAX_W   = (ONE_W <<< (SAMPLE_BITS - 1)) - ONE_W;
   localparam logic signed [ACC_BITS-1:0] OUT_MIN_W   = -OUT_MAX_W - ONE_W;

   // Saturate a wide value to the signed state range.
   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [ACC_BITS-1:0] v
   );
      logic signed [STATE_BITS-1:0] r;
      if (v > STATE_MAX_W) begin
         r = STATE_MAX_W[STATE_BITS-1:0];
      end else if (v < STATE_MIN_W) begin
         r = STATE_MIN_W[STATE_BITS-1:0];
      end else begin
         r = v[STATE_BITS-1:0];
      end
      return r;
   endfunction

   // Item registers.
   logic        [CHAN_BITS-1:0]  ch_ff, ch_in;
   logic signed [STATE_BITS-1:0] x_ff, x_in;
   logic signed [STATE_BITS-1:0] w_ff, w_in;

   // Multiplier and accumulator.
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic                         prod_hi_ff;
   logic                         prod_vld_ff;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;

   // Delay store, its valid bits and the registered read data.
   logic signed [STATE_BITS-1:0] d1_mem_ff [DEPTH];
   logic signed [STATE_BITS-1:0] d2_mem_ff [DEPTH];
   logic        [DEPTH-1:0]      vld_ff;
   logic signed [STATE_BITS-1:0] d1_q_ff, d2_q_ff;
   logic                         vld_q_ff;

   // Output payload.
   logic        [CHAN_BITS-1:0]        rsp_channel_out_ff;
   logic signed [PORT_SAMPLE_BITS-1:0] rsp_filtered_ff, rsp_filtered_in;

   logic        [IDX_WIDE-1:0]         idx_wide;
   logic        [IDX_BITS-1:0]         idx;
   logic signed [STATE_BITS-1:0]       d1_eff, d2_eff, opd;
   logic signed [PART_BITS-1:0]        part;
   logic signed [COEF_BITS-1:0]        coef;
   logic signed [ACC_BITS-1:0]         addend;
   logic        [ZEXT_BITS-1:0]        sample_zext;
   logic        [SAMPLE_BITS-1:0]      raw;
   logic signed [ACC_BITS-1:0]         sample_w, scaled;
   logic signed [ACC_BITS-1:0]         y_round, y_sat;

   // Delay store address of the current channel and section.
   always_comb begin
      idx_wide = IDX_WIDE'(ch_ff) * IDX_WIDE'(SECTIONS) + IDX_WIDE'(cmd.sec);
      idx      = idx_wide[IDX_BITS-1:0];
   end

   assign status.ch_ok = (ZEXT_BITS'(ch_ff) < ZEXT_BITS'(CHANNELS));

   // Entries never written read as zero.
   assign d1_eff = vld_q_ff ? d1_q_ff : '0;
   assign d2_eff = vld_q_ff ? d2_q_ff : '0;

   // Input scaling to the state format.
   always_comb begin
      sample_zext = ZEXT_BITS'(unsigned'(req_sample));
      raw         = sample_zext[SAMPLE_BITS-1:0];
      sample_w    = {{(ACC_BITS - SAMPLE_BITS){raw[SAMPLE_BITS-1]}}, raw};
      scaled      = sample_w <<< STATE_FRACTION_BITS;
   end

   // Operand select and one partial product of the shared multiplier.
   always_comb begin
      case (cmd.opd_sel)
         OPD_D1:  opd = d1_eff;
         OPD_D2:  opd = d2_eff;
         OPD_W:   opd = w_ff;
         default: opd = '0;
      endcase
      if (cmd.hi_half) begin
         part = {opd[STATE_BITS-1], opd[STATE_BITS-1:HALF_BITS]};
      end else begin
         part = {1'b0, opd[HALF_BITS-1:0]};
      end
      coef    = coef_value(cmd.sec, cmd.coef_sel);
      prod_in = coef * part;
   end

   // Accumulator; the rounding offset is loaded with the first term.
   always_comb begin
      if (prod_hi_ff) begin
         addend = ACC_BITS'(prod_ff) <<< HALF_BITS;
      end else begin
         addend = ACC_BITS'(prod_ff);
      end
      if (cmd.acc_init_x) begin
         acc_in = (ACC_BITS'(x_ff) <<< COEF_FRAC) + ROUND_HALF;
      end else if (cmd.acc_init_zero) begin
         acc_in = ROUND_HALF;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   // Section results and item load.
   always_comb begin
      ch_in = ch_ff;
      x_in  = x_ff;
      w_in  = w_ff;
      if (cmd.load_in) begin
         ch_in = req_channel;
         x_in  = sat_state(scaled);
      end
      if (cmd.w_take) begin
         w_in = sat_state(acc_ff >>> COEF_FRAC);
      end
      if (cmd.y_take) begin
         x_in = sat_state(acc_ff >>> COEF_FRAC);
      end
   end

   // Final rounding to the sample range.
   always_comb begin
      y_round = (ACC_BITS'(x_ff) + OUT_HALF) >>> STATE_FRACTION_BITS;
      if (y_round > OUT_MAX_W) begin
         y_sat = OUT_MAX_W;
      end else if (y_round < OUT_MIN_W) begin
         y_sat = OUT_MIN_W;
      end else begin
         y_sat = y_round;
      end
      rsp_filtered_in = status.ch_ok ? y_sat[PORT_SAMPLE_BITS-1:0] : '0;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         vld_ff      <= '0;
      end else begin
         prod_vld_ff <= cmd.mul_en;
         if (cmd.y_take) begin
            vld_ff[idx] <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ch_ff      <= ch_in;
      x_ff       <= x_in;
      w_ff       <= w_in;
      acc_ff     <= acc_in;
      prod_ff    <= prod_in;
      prod_hi_ff <= cmd.hi_half;
      if (cmd.out_take) begin
         rsp_channel_out_ff <= ch_ff;
         rsp_filtered_ff    <= rsp_filtered_in;
      end
   end

   // Delay store: one read and one write port.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         d1_q_ff  <= d1_mem_ff[idx];
         d2_q_ff  <= d2_mem_ff[idx];
         vld_q_ff <= vld_ff[idx];
      end
      if (cmd.y_take) begin
         d1_mem_ff[idx] <= w_ff;
         d2_mem_ff[idx] <= d1_eff;
      end
   end

   assign rsp_channel_out = rsp_channel_out_ff;
   assign rsp_filtered    = rsp_filtered_ff;

   `ASSERT_IMPLIES(a_take_after_flush, clock, reset, cmd.w_take || cmd.y_take, !prod_vld_ff, "section sum taken before last product was added")
   `ASSERT_IMPLIES(a_write_in_range, clock, reset, cmd.y_take, status.ch_ok, "delay store written for a channel outside the table")

endmodule

`default_nettype wire

// ===== design/multichannel_biquad_cascade_lowpass.sv =====
// Top level of the multichannel fifth-order Butterworth low-pass biquad cascade.
//
// Usage: each request beat carries a channel number and a signed sample. The
// sample runs through three direct form II second-order sections that use the
// delay words of that channel, and one response beat returns the channel and
// the filtered sample, rounded and saturated to the sample range.
// A channel at or above CHANNELS leaves the delay words alone and returns zero.
// Both channels use valid and stall; a beat moves when valid is high and stall
// is low. req_stall is low only while the block waits for a new beat.
// Steps: an accept step; per section a read step, five products, each in a low
// and a high partial step on the single 24 x 21 bit multiplier, plus flush and
// take steps; then a step that loads the output register. A channel outside the
// table goes straight from the read step to the output load. A new beat is
// accepted only after the output register has been loaded for the last one.
// The output register holds a finished beat while rsp_stall is high; the block
// still accepts and works on the next beat, then waits until the register frees.
// Reset clears the control state, the output valid and the valid bits of all delay words, which then read as zero.
`default_nettype none

module multichannel_biquad_cascade_lowpass #(
   parameter int unsigned CHANNELS            = mbc_pkg::CHANNELS_DEF,
   parameter int unsigned SAMPLE_BITS         = mbc_pkg::SAMPLE_BITS_DEF,
   parameter int unsigned STATE_FRACTION_BITS = mbc_pkg::STATE_FRACTION_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_stall,
   input  logic        [mbc_pkg::CHAN_BITS-1:0]        req_channel,
   input  logic signed [mbc_pkg::PORT_SAMPLE_BITS-1:0] req_sample,
   output logic                                        rsp_valid,
   input  logic                                        rsp_stall,
   output logic        [mbc_pkg::CHAN_BITS-1:0]        rsp_channel_out,
   output logic signed [mbc_pkg::PORT_SAMPLE_BITS-1:0] rsp_filtered
);
   import mbc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Controller.
   mbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   mbc_datapath #(
      .CHANNELS            (CHANNELS),
      .SAMPLE_BITS         (SAMPLE_BITS),
      .STATE_FRACTION_BITS (STATE_FRACTION_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_channel_out (rsp_channel_out),
      .rsp_filtered    (rsp_filtered)
   );

endmodule

`default_nettype wire
